FILE: hdl/lf2i_pkg.sv
// Shared types and constants for the legacy float to IEEE single converter.
// No dependencies.
package lf2i_pkg;

    localparam int WORD_W = 32;
    localparam int EXP_W  = 9;
    localparam int MANT_W = 22;
    localparam int LZ_W   = 5;
    // signed exponent after normalization: range -21..511
    localparam int NEXP_W = 10;
    localparam int FRAC_W = 23;

    localparam int EXP_OVF_MAX  = 384;
    localparam int EXP_UNF_MIN  = 108;
    localparam int EXP_NORM_OFS = 130;
    localparam int EXP_SUB_REF  = 129;

    localparam logic [WORD_W-2:0] INF_MAG = 31'h7F80_0000;

    typedef struct packed {
        logic               sign;
        logic [EXP_W-1:0]   exp;
        logic [MANT_W-1:0]  mant;
        logic               last;
    } t_unpacked;

    typedef struct packed {
        logic               sign;
        logic [EXP_W-1:0]   exp;
        logic [MANT_W-1:0]  mant;
        logic [LZ_W-1:0]    lz;
        logic               last;
    } t_counted;

    typedef struct packed {
        logic                     sign;
        logic signed [NEXP_W-1:0] exp;
        logic [MANT_W-1:0]        mant;
        logic                     zero;
        logic                     last;
    } t_normed;

endpackage

FILE: hdl/legacy_float32_to_ieee_single_top.sv
// Channel   | Ports                                   | Handshake
// ----------+-----------------------------------------+------------------------------
// request   | i_source_word, i_last_in                | start && !busy
// result    | o_ieee_word, o_last_out                 | o_valid, one cycle, no stall
//
// Four register stages: negate, leading zero count, normalize, pack.
// The pipeline takes one request per cycle.
// busy is tied low: the pipeline never backs up since the result side cannot stall.
// Synchronous active-low reset clears the valid bits only; no warm-up needed.
// Top of the converter; depends on lf2i_pkg, lf2i_unpack, lf2i_norm, lf2i_pack.
module legacy_float32_to_ieee_single_top
    import lf2i_pkg::*;
(
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              start,
    output logic              busy,
    input  logic [WORD_W-1:0] i_source_word,
    input  logic              i_last_in,
    output logic              o_valid,
    output logic [WORD_W-1:0] o_ieee_word,
    output logic              o_last_out
);

    logic      s1_valid;
    t_unpacked s1_data;
    logic      s3_valid;
    t_normed   s3_data;

    assign busy = 1'b0;

    lf2i_unpack u_unpack (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (start && !busy),
        .i_word  (i_source_word),
        .i_last  (i_last_in),
        .o_valid (s1_valid),
        .o_data  (s1_data)
    );

    lf2i_norm u_norm (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (s1_valid),
        .i_data  (s1_data),
        .o_valid (s3_valid),
        .o_data  (s3_data)
    );

    lf2i_pack u_pack (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (s3_valid),
        .i_data  (s3_data),
        .o_valid (o_valid),
        .o_word  (o_ieee_word),
        .o_last  (o_last_out)
    );

`ifndef SYNTH
    a_latency_fwd: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        start |-> ##4 o_valid)
        else $error("request did not produce a result after 4 cycles");

    a_latency_rev: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> $past(start, 4))
        else $error("result without matching request");

    a_last_follows: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        start |-> ##4 (o_last_out == $past(i_last_in, 4)))
        else $error("last flag lost in pipeline");

    a_no_nan: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_ieee_word[30:23] == 8'hFF) |-> (o_ieee_word[22:0] == '0))
        else $error("NaN pattern produced");
`endif

endmodule

FILE: hdl/lf2i_unpack.sv
// Stage 1: sign strip by two's complement negation, field split.
// Depends on lf2i_pkg.
module lf2i_unpack
    import lf2i_pkg::*;
(
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_valid,
    input  logic [WORD_W-1:0] i_word,
    input  logic              i_last,
    output logic              o_valid,
    output t_unpacked         o_data
);

    logic              r_valid;
    t_unpacked         r_data;
    t_unpacked         n_data;
    logic [WORD_W-1:0] mag;

    always_comb begin
        mag = i_word[WORD_W-1] ? (~i_word + WORD_W'(1)) : i_word;
        n_data.sign = i_word[WORD_W-1];
        n_data.exp  = mag[MANT_W+EXP_W-1:MANT_W];
        n_data.mant = mag[MANT_W-1:0];
        n_data.last = i_last;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= i_valid;
        end
        r_data <= n_data;
    end

    assign o_valid = r_valid;
    assign o_data  = r_data;

endmodule

FILE: hdl/lf2i_norm.sv
// Stages 2 and 3: leading zero count, then normalizing shift and exponent adjust.
// Depends on lf2i_pkg.
module lf2i_norm
    import lf2i_pkg::*;
(
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      i_valid,
    input  t_unpacked i_data,
    output logic      o_valid,
    output t_normed   o_data
);

    logic     r_cnt_valid;
    t_counted r_cnt;
    t_counted n_cnt;
    logic     r_valid;
    t_normed  r_data;
    t_normed  n_data;

    // highest set bit wins
    always_comb begin
        n_cnt.sign = i_data.sign;
        n_cnt.exp  = i_data.exp;
        n_cnt.mant = i_data.mant;
        n_cnt.last = i_data.last;
        n_cnt.lz   = '0;
        for (int i = 0; i < MANT_W; i++) begin
            if (i_data.mant[i]) begin
                n_cnt.lz = LZ_W'(MANT_W - 1 - i);
            end
        end
    end

    always_comb begin
        n_data.sign = r_cnt.sign;
        n_data.last = r_cnt.last;
        n_data.zero = (r_cnt.mant == '0);
        n_data.mant = r_cnt.mant << r_cnt.lz;
        n_data.exp  = $signed(NEXP_W'(r_cnt.exp)) - $signed(NEXP_W'(r_cnt.lz));
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt_valid <= 1'b0;
            r_valid     <= 1'b0;
        end else begin
            r_cnt_valid <= i_valid;
            r_valid     <= r_cnt_valid;
        end
        r_cnt  <= n_cnt;
        r_data <= n_data;
    end

    assign o_valid = r_valid;
    assign o_data  = r_data;

endmodule

FILE: hdl/lf2i_pack.sv
// Stage 4: range classification and IEEE single packing, truncating.
// Depends on lf2i_pkg.
module lf2i_pack
    import lf2i_pkg::*;
(
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_valid,
    input  t_normed           i_data,
    output logic              o_valid,
    output logic [WORD_W-1:0] o_word,
    output logic              o_last
);

    logic                     r_valid;
    logic [WORD_W-1:0]        r_word;
    logic                     r_last;
    logic [WORD_W-1:0]        n_word;
    logic signed [NEXP_W-1:0] norm_exp;
    logic signed [NEXP_W-1:0] sub_shift;
    logic [FRAC_W-1:0]        sub_frac;

    always_comb begin
        norm_exp  = i_data.exp - NEXP_W'(EXP_NORM_OFS);
        sub_shift = NEXP_W'(EXP_SUB_REF) - i_data.exp;
        sub_frac  = {1'b0, i_data.mant} >> sub_shift[LZ_W-1:0];
        n_word    = {i_data.sign, {(WORD_W-1){1'b0}}};
        priority if (i_data.zero) begin
            n_word = {i_data.sign, {(WORD_W-1){1'b0}}};
        end else if (i_data.exp > NEXP_W'(EXP_OVF_MAX)) begin
            n_word = {i_data.sign, INF_MAG};
        end else if (i_data.exp < NEXP_W'(EXP_UNF_MIN)) begin
            n_word = {i_data.sign, {(WORD_W-1){1'b0}}};
        end else if (i_data.exp > NEXP_W'(EXP_NORM_OFS)) begin
            n_word = {i_data.sign, norm_exp[7:0], i_data.mant[MANT_W-2:0], 2'b00};
        end else if (i_data.exp == NEXP_W'(EXP_NORM_OFS)) begin
            n_word = {i_data.sign, 8'h00, i_data.mant, 1'b0};
        end else begin
            // subnormal; shift is zero at the reference exponent
            n_word = {i_data.sign, 8'h00, sub_frac};
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= i_valid;
        end
        r_word <= n_word;
        r_last <= i_data.last;
    end

    assign o_valid = r_valid;
    assign o_word  = r_word;
    assign o_last  = r_last;

endmodule

FILE: test/tb_top.sv
// Self-checking bench for legacy_float32_to_ieee_single_top: directed table, then random words.
// Expected IEEE singles: typed-in rows or local predictor; depends on lf2i_pkg, converter RTL.
module tb_top;
    timeunit 1ns;
    timeprecision 1ps;

    import lf2i_pkg::*;

    localparam int CLK_HALF       = 6;
    localparam int RESET_CYCLES   = 7;
    localparam int RANDOM_WORDS   = 850;
    localparam int DRAIN_CYCLES   = 8;
    localparam int WATCHDOG_LIMIT = 200;
    localparam int DIR_ROWS       = 22;

    typedef struct packed {
        logic [WORD_W-1:0] word;
        logic              last;
        logic              fixed;   // expected value typed in below
        logic [WORD_W-1:0] ieee;
    } t_dir_row;

    typedef struct packed {
        logic [WORD_W-1:0] ieee;
        logic              last;
    } t_ieee_result;

    localparam t_dir_row DIR_TABLE [0:DIR_ROWS-1] = '{
        '{32'h0000_0000, 1'b0, 1'b1, 32'h0000_0000},
        '{32'h8000_0000, 1'b1, 1'b1, 32'h8000_0000},   // negates to itself
        '{32'h7FC0_0000, 1'b0, 1'b1, 32'h0000_0000},   // zero mantissa, max exponent
        '{32'h7FFF_FFFF, 1'b0, 1'b1, 32'h7F80_0000},
        '{32'h8000_0001, 1'b1, 1'b1, 32'hFF80_0000},
        '{32'hFFFF_FFFF, 1'b0, 1'b1, 32'h8000_0000},   // magnitude 1, deep underflow
        '{32'h0000_0001, 1'b0, 1'b1, 32'h0000_0000},
        '{32'h1AE0_0000, 1'b0, 1'b1, 32'h0000_0000},   // one below underflow edge
        '{32'h1B20_0000, 1'b1, 1'b0, 32'h0},           // lowest subnormal exponent
        '{32'h2020_0000, 1'b0, 1'b0, 32'h0},
        '{32'h2060_0000, 1'b0, 1'b0, 32'h0},
        '{32'h20A0_0000, 1'b1, 1'b0, 32'h0},
        '{32'h20D0_0000, 1'b0, 1'b0, 32'h0},           // lands on 130 after one shift
        '{32'h20E0_0000, 1'b0, 1'b0, 32'h0},           // smallest normal
        '{32'h6020_0000, 1'b0, 1'b0, 32'h0},           // largest normal exponent
        '{32'h6060_0000, 1'b1, 1'b1, 32'h7F80_0000},
        '{32'h6040_0001, 1'b0, 1'b0, 32'h0},           // overflow field, 21 shifts back
        '{32'hBFE0_0000, 1'b0, 1'b0, 32'h0},
        '{32'h403F_FFFF, 1'b1, 1'b0, 32'h0},
        '{32'h5555_5555, 1'b0, 1'b0, 32'h0},
        '{32'hAAAA_AAAA, 1'b1, 1'b0, 32'h0},
        '{32'hDFE0_0000, 1'b0, 1'b0, 32'h0}            // negative subnormal
    };

    logic              i_clk = 1'b0;
    logic              i_rst_n = 1'b0;
    logic              start = 1'b0;
    logic              busy;
    logic [WORD_W-1:0] i_source_word = '0;
    logic              i_last_in = 1'b0;
    logic              o_valid;
    logic [WORD_W-1:0] o_ieee_word;
    logic              o_last_out;

    // sideband that travels with the request: typed-in expectation
    logic              req_fixed = 1'b0;
    logic [WORD_W-1:0] req_ieee = '0;

    t_ieee_result ieee_expect_q [$];
    t_ieee_result pending_r;
    int           mismatch_count = 0;
    int           idle_cycles = 0;

    legacy_float32_to_ieee_single_top u_top (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .start        (start),
        .busy         (busy),
        .i_source_word(i_source_word),
        .i_last_in    (i_last_in),
        .o_valid      (o_valid),
        .o_ieee_word  (o_ieee_word),
        .o_last_out   (o_last_out)
    );

    initial begin
        forever #(CLK_HALF) i_clk = ~i_clk;
    end

    function automatic logic [WORD_W-1:0] predict_ieee(input logic [WORD_W-1:0] w);
        logic              sign;
        logic [WORD_W-1:0] mag;
        logic [MANT_W-1:0] m;
        int                e;
        sign = w[WORD_W-1];
        mag  = sign ? (~w + 32'd1) : w;
        m    = mag[MANT_W-1:0];
        if (m == '0) begin
            return {sign, 31'b0};
        end
        e = int'(mag[WORD_W-2:MANT_W]);
        while (!m[MANT_W-1]) begin
            m = m << 1;
            e--;
        end
        if (e > EXP_OVF_MAX) begin
            return {sign, INF_MAG};
        end
        if (e < EXP_UNF_MIN) begin
            return {sign, 31'b0};
        end
        if (e > EXP_NORM_OFS) begin
            return {sign, 8'(e - EXP_NORM_OFS), m[MANT_W-2:0], 2'b00};
        end
        if (e == EXP_NORM_OFS) begin
            return {sign, 8'b0, m, 1'b0};
        end
        if (e == EXP_SUB_REF) begin
            return {sign, 9'b0, m};
        end
        return {sign, 9'b0, m >> (EXP_SUB_REF - e)};
    endfunction

    // Mostly built words: exponent near the subnormal or overflow edges or fully random,
    // random leading zeros in the mantissa, random sign applied by negation.
    function automatic logic [WORD_W-1:0] make_word();
        logic [EXP_W-1:0]  ex;
        logic [MANT_W-1:0] mant;
        logic [WORD_W-1:0] mag;
        int                pick;
        pick = $urandom_range(0, 5);
        if (pick == 0) begin
            return $urandom();
        end
        case ($urandom_range(0, 2))
            0:       ex = EXP_W'($urandom_range(EXP_UNF_MIN - 8, EXP_NORM_OFS + 10));
            1:       ex = EXP_W'($urandom_range(EXP_OVF_MAX - 14, EXP_OVF_MAX + 16));
            default: ex = EXP_W'($urandom());
        endcase
        if (pick == 1) begin
            mant = MANT_W'(1) << $urandom_range(0, MANT_W - 1);
        end else begin
            mant = MANT_W'($urandom()) >> $urandom_range(0, MANT_W - 1);
        end
        mag = {1'b0, ex, mant};
        return $urandom_range(0, 1) ? (~mag + 32'd1) : mag;
    endfunction

    task automatic report_mismatch(input string what, input logic [WORD_W-1:0] got,
                                   input logic [WORD_W-1:0] want);
        $display("%0t ns: mismatch on %s: got %h, expected %h", $realtime, what, got, want);
        mismatch_count++;
    endtask

    task automatic send_request(input logic [WORD_W-1:0] word, input logic last,
                                input logic fixed, input logic [WORD_W-1:0] ieee,
                                input int gap);
        if (gap > 0) begin
            start <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        start         <= 1'b1;
        i_source_word <= word;
        i_last_in     <= last;
        req_fixed     <= fixed;
        req_ieee      <= ieee;
        do @(posedge i_clk); while (busy);
    endtask

    task automatic wait_drained();
        start <= 1'b0;
        @(posedge i_clk);
        while (ieee_expect_q.size() != 0) @(posedge i_clk);
    endtask

    // result check and watchdog
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (start && !busy) begin
                pending_r.ieee = req_fixed ? req_ieee : predict_ieee(i_source_word);
                pending_r.last = i_last_in;
                ieee_expect_q.push_back(pending_r);
            end
            if (o_valid) begin
                if (ieee_expect_q.size() == 0) begin
                    report_mismatch("unexpected result", o_ieee_word, '0);
                end else begin
                    pending_r = ieee_expect_q.pop_front();
                    if (o_ieee_word !== pending_r.ieee) begin
                        report_mismatch("ieee_word", o_ieee_word, pending_r.ieee);
                    end
                    if (o_last_out !== pending_r.last) begin
                        report_mismatch("last_out", 32'(o_last_out), 32'(pending_r.last));
                    end
                end
            end
            if ((start && !busy) || o_valid) begin
                idle_cycles = 0;
            end else begin
                idle_cycles++;
            end
            if (idle_cycles >= WATCHDOG_LIMIT) begin
                $display("timeout: no request or result for %0d cycles", idle_cycles);
                $display("FAIL");
                $finish;
            end
        end
    end

    initial begin
        int  gap;
        bit  burst;
        repeat (RESET_CYCLES) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        for (int i = 0; i < DIR_ROWS; i++) begin
            gap = (i < DIR_ROWS / 2) ? 0 : $urandom_range(0, 9);
            send_request(DIR_TABLE[i].word, DIR_TABLE[i].last, DIR_TABLE[i].fixed,
                         DIR_TABLE[i].ieee, gap);
        end
        wait_drained();

        burst = 1'b0;
        for (int i = 0; i < RANDOM_WORDS; i++) begin
            if (i % 40 == 0) begin
                burst = ($urandom_range(0, 2) == 0);
            end
            if (i == RANDOM_WORDS / 2) begin
                wait_drained();
            end
            gap = burst ? 0 : $urandom_range(0, 9);
            send_request(make_word(), 1'($urandom()), 1'b0, '0, gap);
        end

        wait_drained();
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (ieee_expect_q.size() != 0) begin
            report_mismatch("missing results", 32'(ieee_expect_q.size()), '0);
        end
        if (mismatch_count == 0) begin
            $display("PASS");
        end else begin
            $display("FAIL");
        end
        $finish;
    end

endmodule

FILE: sim.f
hdl/lf2i_pkg.sv
hdl/lf2i_unpack.sv
hdl/lf2i_norm.sv
hdl/lf2i_pack.sv
hdl/legacy_float32_to_ieee_single_top.sv
test/tb_top.sv
